@@ design/fdcr_pkg.sv @@
// ----------------------------------------------------------------------------
// fdcr_pkg
// Shared types, codes and the default parameter table for the floppy
// controller register front end.
// ----------------------------------------------------------------------------
package fdcr_pkg;

  localparam int unsigned PARAM_WORDS = 16;
  localparam int unsigned PTR_W       = $clog2(PARAM_WORDS);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_MODE  = 2'd2
  } cmd_t;

  localparam logic [2:0] SEL_IGNORED    = 3'd2;
  localparam logic [2:0] SEL_PARAM      = 3'd3;
  localparam logic [2:0] SEL_STATUS_CLR = 3'd6;
  localparam logic [2:0] SEL_STATUS_SET = 3'd7;
  localparam logic [2:0] STATUS_REG     = 3'd6;

  localparam logic [7:0] REVERT_VALUE = 8'hF8;
  localparam logic [7:0] UNLOCK_MASK  = 8'h40;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] reg_offset;
    logic [7:0] data_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pass_through;
    logic       new_mode_active;
  } result_t;

  // Power-up contents of the parameter RAM; entries past the table are zero
  function automatic logic [7:0] default_param(input int unsigned idx);
    logic [7:0] val;
    case (idx)
      0:       val = 8'h38;
      1:       val = 8'h18;
      2:       val = 8'h41;
      3:       val = 8'h2E;
      4:       val = 8'h2E;
      5:       val = 8'h18;
      6:       val = 8'h18;
      7:       val = 8'h1B;
      8:       val = 8'h1B;
      9:       val = 8'h2F;
      10:      val = 8'h2F;
      11:      val = 8'h19;
      12:      val = 8'h19;
      13:      val = 8'h97;
      14:      val = 8'h1B;
      15:      val = 8'h57;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ design/fdcr_in_stage.sv @@
// ----------------------------------------------------------------------------
// fdcr_in_stage
// Input register: captures one access per transfer and holds it until the
// core has consumed it.
// ----------------------------------------------------------------------------
module fdcr_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fdcr_pkg::item_t in_item,
  input  logic            advance,
  output logic            s_valid,
  output fdcr_pkg::item_t s_item
);
  import fdcr_pkg::*;

  assign in_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item <= in_item;
    end
  end

endmodule

@@ design/fdcr_core.sv @@
// ----------------------------------------------------------------------------
// fdcr_core
// Mode, unlock sequencer, parameter pointer, byte registers and parameter
// RAM; decodes one access and updates state when it advances.
// ----------------------------------------------------------------------------
module fdcr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  fdcr_pkg::item_t   item,
  output fdcr_pkg::result_t result
);
  import fdcr_pkg::*;

  logic             mode_new;
  logic [1:0]       unlock_progress;
  logic [PTR_W-1:0] param_pointer;
  logic [7:0]       byte_regs [8];
  logic [7:0]       param_ram [PARAM_WORDS];

  logic             mode_new_next;
  logic [1:0]       unlock_progress_next;
  logic [PTR_W-1:0] param_pointer_next;
  logic [7:0]       status_next;
  logic [PTR_W-1:0] ptr_inc;
  logic [2:0]       sel;
  logic             reg_we;
  logic             ram_we;
  logic             unlock_bit;
  logic             unlock_want;
  logic [7:0]       rd;
  logic             pass;

  assign sel = item.reg_offset[2:0];
  assign ptr_inc = (param_pointer == PTR_W'(PARAM_WORDS - 1)) ? '0
                                                               : param_pointer + 1'b1;
  assign unlock_bit  = (item.data_in & UNLOCK_MASK) != 8'h00;
  assign unlock_want = (unlock_progress != 2'd1);

  always_comb begin
    mode_new_next        = mode_new;
    unlock_progress_next = unlock_progress;
    param_pointer_next   = param_pointer;
    status_next          = byte_regs[STATUS_REG];
    reg_we               = 1'b0;
    ram_we               = 1'b0;
    rd                   = 8'h00;
    pass                 = 1'b0;
    case (item.command)
      CMD_READ: begin
        if (!mode_new) begin
          pass = 1'b1;
        end else if (sel == SEL_PARAM) begin
          rd                 = param_ram[param_pointer];
          param_pointer_next = ptr_inc;
        end else begin
          rd = byte_regs[sel];
        end
      end
      CMD_WRITE: begin
        if (!mode_new) begin
          pass = 1'b1;
        end else begin
          case (sel)
            SEL_IGNORED: begin
            end
            SEL_PARAM: begin
              ram_we             = 1'b1;
              param_pointer_next = ptr_inc;
            end
            SEL_STATUS_CLR: begin
              status_next        = byte_regs[STATUS_REG] & ~item.data_in;
              param_pointer_next = '0;
              if (item.data_in == REVERT_VALUE) begin
                mode_new_next = 1'b0;
              end
            end
            SEL_STATUS_SET: begin
              status_next = byte_regs[STATUS_REG] | item.data_in;
            end
            default: begin
              reg_we = 1'b1;
            end
          endcase
        end
      end
      CMD_MODE: begin
        pass = 1'b1;
        // advance on the expected bit, restart on anything else
        if (unlock_bit == unlock_want) begin
          if (unlock_progress == 2'd3) begin
            unlock_progress_next = 2'd0;
            mode_new_next        = 1'b1;
          end else begin
            unlock_progress_next = unlock_progress + 2'd1;
          end
        end else begin
          unlock_progress_next = 2'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.read_data       = rd;
  assign result.pass_through    = pass;
  assign result.new_mode_active = mode_new_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_new        <= 1'b0;
      unlock_progress <= 2'd0;
      param_pointer   <= '0;
    end else if (advance) begin
      mode_new        <= mode_new_next;
      unlock_progress <= unlock_progress_next;
      param_pointer   <= param_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        byte_regs[i] <= 8'h00;
      end
    end else if (advance) begin
      byte_regs[STATUS_REG] <= status_next;
      if (reg_we) begin
        byte_regs[sel] <= item.data_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PARAM_WORDS; i++) begin
        param_ram[i] <= default_param(i);
      end
    end else if (advance && ram_we) begin
      param_ram[param_pointer] <= item.data_in;
    end
  end

endmodule

@@ design/fdcr_out_stage.sv @@
// ----------------------------------------------------------------------------
// fdcr_out_stage
// Result register: loads a result whenever the input stage holds an access
// and the register is free or being drained.
// ----------------------------------------------------------------------------
module fdcr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              advance,
  input  fdcr_pkg::result_t res_in,
  output logic              out_valid,
  input  logic              out_ready,
  output fdcr_pkg::result_t res_out
);
  import fdcr_pkg::*;

  assign advance = s_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_out <= res_in;
    end
  end

endmodule

@@ design/fdc_register_file_with_unlock_unit.sv @@
// ----------------------------------------------------------------------------
// fdc_register_file_with_unlock_unit
// An access is held in the input register, then loaded into the result register.
// One access per cycle unless out_ready holds the result register; the two
// registers let a new transfer in while a finished result still waits.
// Reset: legacy mode, unlock sequence and pointer cleared, byte registers
// zero, parameter RAM reloaded with its default table in the reset cycle.
// ----------------------------------------------------------------------------
module fdc_register_file_with_unlock_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] reg_offset,
  input  logic [7:0] data_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       pass_through,
  output logic       new_mode_active
);
  import fdcr_pkg::*;

  item_t   in_item;
  item_t   s_item;
  logic    s_valid;
  logic    advance;
  result_t core_res;
  result_t out_res;

  assign in_item.command    = cmd_t'(command);
  assign in_item.reg_offset = reg_offset;
  assign in_item.data_in    = data_in;

  fdcr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  fdcr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s_item),
    .result  (core_res)
  );

  fdcr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_valid),
    .advance   (advance),
    .res_in    (core_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  assign read_data       = out_res.read_data;
  assign pass_through    = out_res.pass_through;
  assign new_mode_active = out_res.new_mode_active;

  // Pass-through accesses never return data
  a_pass_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && pass_through |-> read_data == 8'h00)
    else $error("pass-through result carries read data");

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A held access moves to the result register when it is free
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s_valid && !out_valid |=> out_valid)
    else $error("held access did not reach the result register");

endmodule
